### hdl/rre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types, codes and constants of the round-trip time and retransmission
// timeout estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int FracBitsDef = 4;

  localparam int OpW     = 2;
  localparam int MeasW   = 20;
  localparam int CfgMsW  = 20;
  localparam int RetryW  = 8;
  localparam int RtoW    = 36;
  localparam int AlarmW  = 23;
  localparam int EstW    = 24;
  localparam int AddrW   = 4;
  localparam int ApbW    = 32;

  localparam logic [OpW-1:0] OpInit    = 2'd0;
  localparam logic [OpW-1:0] OpNewPkt  = 2'd1;
  localparam logic [OpW-1:0] OpMeasure = 2'd2;
  localparam logic [OpW-1:0] OpTimeout = 2'd3;

  localparam logic [1:0] RegRtoMin     = 2'd0;
  localparam logic [1:0] RegRtoMax     = 2'd1;
  localparam logic [1:0] RegMaxRetries = 2'd2;

  localparam logic [CfgMsW-1:0] RtoMinRst     = 20'd2000;
  localparam logic [CfgMsW-1:0] RtoMaxRst     = 20'd60000;
  localparam logic [RetryW-1:0] MaxRetriesRst = 8'd3;

  localparam int DevInitMs = 500;
  localparam int RtoInitMs = 2000;
  localparam int MsPerSec  = 1000;

  typedef struct packed {
    logic [CfgMsW-1:0] rto_min;
    logic [CfgMsW-1:0] rto_max;
    logic [RetryW-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic [EstW-1:0] rtt_deviation;
    logic [EstW-1:0] smoothed_rtt;
    logic            give_up;
    logic [RtoW-1:0] rto;
  } res_t;

endpackage

### hdl/rtt_rto_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_rto_estimator
// Retransmission timeout estimator with smoothed round-trip time and mean
// deviation tracking.
//
// Events enter on the s_axis channel: tuser carries the opcode (init, new
// packet, measurement, timeout) and tdata the measured round-trip time in
// milliseconds. Every event yields exactly one result transfer on m_axis
// with the timeout, its value in whole seconds, the give-up flag, and the
// smoothed estimate and deviation after the update.
// The block accepts one event per cycle unless m_axis stalls. An event passes
// an input register, the state update, the seconds conversion and the output
// register; the state update works directly on the registered state, so
// consecutive events can follow back to back. When m_axis is stalled the
// stages fill up and s_axis tready falls only once every stage holds a
// transfer. Reset empties the pipeline and restores the register and estimator
// reset values. The user must write the clamps and the retry limit over the
// APB port only while no event is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module rtt_rto_estimator
  import rre_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,  // measured_ms [19:0], zero [23:20]
  input  logic [OpW-1:0]   s_axis_tuser,  // opcode [1:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // rto_ms_q4 [35:0], alarm_seconds [58:36], give_up [59], smoothed_rtt_q4 [83:60],
  // rtt_deviation_q4 [107:84], zero [111:108]
  output logic [111:0]     m_axis_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready
);

  cfg_t              cfg;
  logic              v0_q;
  logic [OpW-1:0]    op0_q;
  logic [MeasW-1:0]  meas0_q;
  logic              core_ready;
  logic              v1;
  logic              alarm_ready;
  res_t              res1, res_out;
  logic [AlarmW-1:0] alarm;

  rre_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !v0_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op0_q   <= s_axis_tuser;
      meas0_q <= s_axis_tdata[MeasW-1:0];
    end
  end

  rre_core #(
    .FracBits (FracBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (v0_q),
    .in_ready_o  (core_ready),
    .op_i        (op0_q),
    .meas_i      (meas0_q),
    .out_valid_o (v1),
    .out_ready_i (alarm_ready),
    .res_o       (res1)
  );

  rre_alarm #(
    .FracBits (FracBits)
  ) u_alarm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1),
    .in_ready_o  (alarm_ready),
    .res_i       (res1),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res_out),
    .alarm_o     (alarm)
  );

  assign m_axis_tdata = {4'b0, res_out.rtt_deviation, res_out.smoothed_rtt,
                         res_out.give_up, alarm, res_out.rto};

endmodule

### hdl/rre_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_cfg
// Configuration register file with a write/read bus port: timeout clamps and
// the retry limit.
// ----------------------------------------------------------------------------
module rre_cfg
  import rre_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output logic [ApbW-1:0]  prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rto_min     <= RtoMinRst;
      cfg_q.rto_max     <= RtoMaxRst;
      cfg_q.max_retries <= MaxRetriesRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegRtoMin:     cfg_q.rto_min     <= pwdata[CfgMsW-1:0];
        RegRtoMax:     cfg_q.rto_max     <= pwdata[CfgMsW-1:0];
        RegMaxRetries: cfg_q.max_retries <= pwdata[RetryW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegRtoMin:     prdata = ApbW'(cfg_q.rto_min);
      RegRtoMax:     prdata = ApbW'(cfg_q.rto_max);
      RegMaxRetries: prdata = ApbW'(cfg_q.max_retries);
      default:       prdata = '0;
    endcase
  end

endmodule

### hdl/rre_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_core
// Estimator state and its registered update: smoothed round-trip time, mean
// deviation, clamped timeout with doubling on timeouts, and retry counting.
// ----------------------------------------------------------------------------
module rre_core
  import rre_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [MeasW-1:0] meas_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output res_t             res_o
);

  localparam int ScaledW = MeasW + FracBits;
  localparam int DeltaW  = ((ScaledW > EstW) ? ScaledW : EstW) + 1;
  localparam logic [EstW-1:0] DevInit = EstW'(DevInitMs << FracBits);
  localparam logic [RtoW-1:0] RtoInit = RtoW'(RtoInitMs << FracBits);
  localparam logic [RtoW-1:0] RtoSat  = '1;
  localparam logic [RtoW-1:0] RtoHalf = RtoSat >> 1;
  localparam logic [EstW-1:0] EstMax  = '1;

  logic [EstW-1:0]   srtt_q, srtt_d;
  logic [EstW-1:0]   dev_q, dev_d;
  logic [RtoW-1:0]   rto_q, rto_d;
  logic [RetryW-1:0] retry_q, retry_d;
  logic              give_up_q, give_up_d;
  logic              valid_q;
  logic              adv;

  logic signed [DeltaW-1:0] meas_s, delta, mag, srtt_sum, dev_sum;
  logic [EstW-1:0]          srtt_m, dev_m;
  logic [RtoW-1:0]          rto_m, rto_init_c, lo_lim, hi_lim;
  logic [RetryW:0]          retry_next;

  function automatic logic [EstW-1:0] sat_est(input logic signed [DeltaW-1:0] x);
    logic [EstW-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > $signed({1'b0, (DeltaW-1)'(EstMax)})) begin
      r = EstMax;
    end else begin
      r = x[EstW-1:0];
    end
    return r;
  endfunction

  function automatic logic [RtoW-1:0] clamp_rto(input logic [RtoW-1:0] x,
                                                input logic [RtoW-1:0] lo,
                                                input logic [RtoW-1:0] hi);
    logic [RtoW-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  assign in_ready_o  = !valid_q || out_ready_i;
  assign adv         = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;

  assign lo_lim = RtoW'(cfg_i.rto_min) << FracBits;
  assign hi_lim = RtoW'(cfg_i.rto_max) << FracBits;

  always_comb begin
    meas_s     = $signed(DeltaW'(meas_i) << FracBits);
    delta      = meas_s - $signed(DeltaW'(srtt_q));
    mag        = (delta < 0) ? -delta : delta;
    srtt_sum   = $signed(DeltaW'(srtt_q)) + (delta >>> 3);
    srtt_m     = sat_est(srtt_sum);
    dev_sum    = $signed(DeltaW'(dev_q)) + ((mag - $signed(DeltaW'(dev_q))) >>> 2);
    dev_m      = sat_est(dev_sum);
    rto_m      = clamp_rto(RtoW'(srtt_m) + (RtoW'(dev_m) << 2), lo_lim, hi_lim);
    rto_init_c = clamp_rto(RtoW'(DevInit) << 2, lo_lim, hi_lim);
    retry_next = {1'b0, retry_q} + (RetryW+1)'(1);
  end

  always_comb begin
    srtt_d    = srtt_q;
    dev_d     = dev_q;
    rto_d     = rto_q;
    retry_d   = retry_q;
    give_up_d = 1'b0;
    case (op_i)
      OpInit: begin
        srtt_d  = '0;
        dev_d   = DevInit;
        rto_d   = rto_init_c;
        retry_d = '0;
      end
      OpNewPkt: begin
        retry_d = '0;
      end
      OpMeasure: begin
        srtt_d = srtt_m;
        dev_d  = dev_m;
        rto_d  = rto_m;
      end
      OpTimeout: begin
        rto_d     = (rto_q > RtoHalf) ? RtoSat : (rto_q << 1);
        give_up_d = retry_next > {1'b0, cfg_i.max_retries};
        retry_d   = retry_next[RetryW] ? '1 : retry_next[RetryW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_q  <= '0;
      dev_q   <= DevInit;
      rto_q   <= RtoInit;
      retry_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (adv) begin
        srtt_q  <= srtt_d;
        dev_q   <= dev_d;
        rto_q   <= rto_d;
        retry_q <= retry_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      give_up_q <= give_up_d;
    end
  end

  assign res_o.rto           = rto_q;
  assign res_o.give_up       = give_up_q;
  assign res_o.smoothed_rtt  = srtt_q;
  assign res_o.rtt_deviation = dev_q;

endmodule

### hdl/rre_alarm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_alarm
// Two-stage conversion of the timeout to whole seconds, rounded half up, by a
// reciprocal multiplication; the second stage is the output register.
// ----------------------------------------------------------------------------
module rre_alarm
  import rre_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  res_t              res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output res_t              res_o,
  output logic [AlarmW-1:0] alarm_o
);

  // The timeout plus half a second is divided by 2^(FracBits+3), then by 125.
  localparam int SumW  = RtoW + 1;
  localparam int YW    = SumW - FracBits - 3;
  localparam int ShK   = YW + 7;
  localparam int MulW  = YW + 1;
  localparam int ProdW = YW + MulW;
  localparam logic [SumW-1:0] HalfSec   = SumW'((MsPerSec << FracBits) >> 1);
  localparam logic [63:0]     RecipFull = ((64'd1 << ShK) + 64'd124) / 64'd125;
  localparam logic [MulW-1:0] Recip     = RecipFull[MulW-1:0];

  logic             v2_q, v3_q;
  logic             rdy3;
  res_t             res2_q, res3_q;
  logic [YW-1:0]    y_q;
  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod_q;

  assign rdy3       = !v3_q || out_ready_i;
  assign in_ready_o = !v2_q || rdy3;
  assign sum        = {1'b0, res_i.rto} + HalfSec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res2_q <= res_i;
      y_q    <= sum[SumW-1:FracBits+3];
    end
    if (rdy3 && v2_q) begin
      res3_q <= res2_q;
      prod_q <= ProdW'(y_q) * ProdW'(Recip);
    end
  end

  assign out_valid_o = v3_q;
  assign res_o       = res3_q;
  assign alarm_o     = AlarmW'(prod_q >> ShK);

endmodule

### tb/tb_rtt_rto_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtt_rto_estimator
// Self-checking testbench of the retransmission timeout estimator. A clocked
// driver feeds event transfers from a queue, a predictor tracks the smoothed
// round-trip time, deviation, timeout and retry count of every accepted
// event, and a monitor compares each result transfer field by field. The run
// steps through several clamp and retry-limit settings, including inverted
// clamps and the extremes, with random idling, one long output stall and a
// long run of timeouts that saturates the timeout and the retry count.
// ----------------------------------------------------------------------------
module tb_rtt_rto_estimator;
  import rre_pkg::*;

  localparam int              CycleLimit  = 200000;
  localparam int              StallCycles = 300;
  localparam int              DrainCycles = 8;
  localparam int              RandomOps   = 260;
  localparam longint          EstMax      = (longint'(1) << EstW) - 1;
  localparam longint unsigned RtoFieldMax = (64'd1 << RtoW) - 1;
  localparam longint unsigned SecQ4       = 64'(MsPerSec) << FracBitsDef;
  localparam longint unsigned HalfSecQ4   = SecQ4 >> 1;
  localparam int unsigned     RetrySat    = (1 << RetryW) - 1;
  localparam logic [AddrW-1:0] UnusedAddr = 4'hC;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [MeasW-1:0] ms;
  } op_item_t;

  typedef struct packed {
    logic [RtoW-1:0]   rto;
    logic [AlarmW-1:0] alarm;
    logic              give_up;
    logic [EstW-1:0]   srtt;
    logic [EstW-1:0]   dev;
  } estimate_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata  = '0;  // measured_ms [19:0], zero [23:20]
  logic [OpW-1:0]    s_axis_tuser  = '0;  // opcode [1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // rto_ms_q4 [35:0], alarm_seconds [58:36], give_up [59], smoothed_rtt_q4 [83:60],
  // rtt_deviation_q4 [107:84], zero [111:108]
  logic [111:0]      m_axis_tdata;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [AddrW-1:0]  paddr         = '0;
  logic [ApbW-1:0]   pwdata        = '0;
  logic [ApbW-1:0]   prdata;
  logic              pready;

  op_item_t  pending_ops[$];
  estimate_t estimates_due[$];
  op_item_t  tx_item;
  estimate_t due_est;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 30;
  int rx_idle_pct    = 30;
  logic stall_req    = 1'b0;
  logic stall_ack    = 1'b0;
  int   stall_left   = 0;

  logic [CfgMsW-1:0] lim_min     = RtoMinRst;
  logic [CfgMsW-1:0] lim_max     = RtoMaxRst;
  logic [RetryW-1:0] lim_retries = MaxRetriesRst;
  longint            srtt_q4     = 0;
  longint            dev_q4      = longint'(DevInitMs) << FracBitsDef;
  longint unsigned   rto_q4      = 64'(RtoInitMs) << FracBitsDef;
  int unsigned       retries     = 0;

  rtt_rto_estimator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned clamp_timeout(input longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    lo = {44'd0, lim_min} << FracBitsDef;
    hi = {44'd0, lim_max} << FracBitsDef;
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint clamp_estimate(input longint x);
    if (x < 0) return 0;
    if (x > EstMax) return EstMax;
    return x;
  endfunction

  function automatic estimate_t next_estimate(input logic [OpW-1:0] op,
                                              input logic [MeasW-1:0] ms);
    longint      delta;
    longint      mag;
    int unsigned next_try;
    estimate_t   est;
    est.give_up = 1'b0;
    case (op)
      OpInit: begin
        srtt_q4 = 0;
        dev_q4  = longint'(DevInitMs) << FracBitsDef;
        rto_q4  = clamp_timeout(unsigned'(4 * dev_q4));
        retries = 0;
      end
      OpNewPkt: begin
        retries = 0;
      end
      OpMeasure: begin
        delta   = (longint'(ms) << FracBitsDef) - srtt_q4;
        mag     = (delta < 0) ? -delta : delta;
        srtt_q4 = clamp_estimate(srtt_q4 + (delta >>> 3));
        dev_q4  = clamp_estimate(dev_q4 + ((mag - dev_q4) >>> 2));
        rto_q4  = clamp_timeout(unsigned'(srtt_q4 + 4 * dev_q4));
      end
      OpTimeout: begin
        next_try    = retries + 1;
        rto_q4      = (rto_q4 > (RtoFieldMax >> 1)) ? RtoFieldMax : rto_q4 << 1;
        est.give_up = (next_try > lim_retries);
        retries     = (next_try > RetrySat) ? RetrySat : next_try;
      end
      default: ;
    endcase
    est.rto   = RtoW'(rto_q4);
    est.alarm = AlarmW'((rto_q4 + HalfSecQ4) / SecQ4);
    est.srtt  = EstW'(srtt_q4);
    est.dev   = EstW'(dev_q4);
    return est;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, predicted %0h", what, got, want));
    end
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [ApbW-1:0] wdata, output logic [ApbW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr) begin
      case (addr[AddrW-1:2])
        RegRtoMin:     lim_min     = wdata[CfgMsW-1:0];
        RegRtoMax:     lim_max     = wdata[CfgMsW-1:0];
        RegMaxRetries: lim_retries = wdata[RetryW-1:0];
        default: ;
      endcase
    end
  endtask

  task automatic set_limits(input logic [CfgMsW-1:0] lo, input logic [CfgMsW-1:0] hi,
                            input logic [RetryW-1:0] tries);
    logic [ApbW-1:0] rd;
    apb_access(1'b1, {RegRtoMin, 2'b00}, {12'($urandom()), lo}, rd);
    apb_access(1'b1, {RegRtoMax, 2'b00}, {12'($urandom()), hi}, rd);
    apb_access(1'b1, {RegMaxRetries, 2'b00}, {24'($urandom()), tries}, rd);
    apb_access(1'b1, UnusedAddr, $urandom(), rd);
    apb_access(1'b0, {RegRtoMin, 2'b00}, '0, rd);
    check_field("rto_min_ms readback", rd, lim_min);
    apb_access(1'b0, {RegRtoMax, 2'b00}, '0, rd);
    check_field("rto_max_ms readback", rd, lim_max);
    apb_access(1'b0, {RegMaxRetries, 2'b00}, '0, rd);
    check_field("max_retries readback", rd, lim_retries);
  endtask

  task automatic push_op(input logic [OpW-1:0] op, input logic [MeasW-1:0] ms);
    op_item_t it;
    it.op = op;
    it.ms = ms;
    pending_ops.push_back(it);
  endtask

  function automatic logic [MeasW-1:0] random_rtt();
    case ($urandom_range(9))
      0, 1:    return MeasW'($urandom());
      2:       return $urandom_range(1) ? '1 : '0;
      default: return MeasW'($urandom_range(20, 2000));
    endcase
  endfunction

  // Mostly connection-like traffic: a packet, a few measurements, occasional
  // timeout bursts, with now and then a long burst that drives the timeout up.
  task automatic queue_random_ops(input int count);
    int              n;
    int              run;
    int              pick;
    logic [OpW-1:0]  op;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      run  = 1;
      if (pick < 8) begin
        op = OpInit;
      end else if (pick < 25) begin
        op = OpNewPkt;
      end else if (pick < 70) begin
        op  = OpMeasure;
        run = $urandom_range(1, 5);
      end else begin
        op  = OpTimeout;
        run = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
      end
      repeat (run) begin
        push_op(op, random_rtt());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || estimates_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_item = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, tx_item.ms};
        s_axis_tuser  <= tx_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_req != stall_ack) begin
      stall_left <= StallCycles;
      stall_ack  <= stall_req;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      estimates_due.push_back(next_estimate(s_axis_tuser, s_axis_tdata[MeasW-1:0]));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (estimates_due.size() == 0) begin
        report_mismatch("result transfer with no estimate pending");
      end else begin
        due_est = estimates_due.pop_front();
        check_field("rto_ms_q4", m_axis_tdata[35:0], due_est.rto);
        check_field("alarm_seconds", m_axis_tdata[58:36], due_est.alarm);
        check_field("give_up", m_axis_tdata[59], due_est.give_up);
        check_field("smoothed_rtt_q4", m_axis_tdata[83:60], due_est.srtt);
        check_field("rtt_deviation_q4", m_axis_tdata[107:84], due_est.dev);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A timeout straight after reset, then timeouts past the retry limit, then the
    // estimator swung between the smallest and largest round-trip times.
    push_op(OpTimeout, '0);
    push_op(OpInit, '1);
    push_op(OpTimeout, 20'd5);
    push_op(OpTimeout, 20'd0);
    push_op(OpTimeout, 20'd0);
    push_op(OpTimeout, 20'd0);
    push_op(OpNewPkt, '1);
    push_op(OpMeasure, '0);
    push_op(OpMeasure, '1);
    push_op(OpMeasure, '1);
    push_op(OpMeasure, '0);
    push_op(OpMeasure, 20'd1);
    push_op(OpMeasure, 20'h80000);
    push_op(OpMeasure, 20'd2000);
    push_op(OpTimeout, '0);
    push_op(OpNewPkt, 20'h55555);
    push_op(OpMeasure, 20'd100);
    push_op(OpInit, '0);
    push_op(OpMeasure, 20'hAAAAA);
    queue_random_ops(RandomOps);
    wait_drained();

    set_limits('0, '1, '0);
    stall_req <= ~stall_req;
    queue_random_ops(RandomOps);
    wait_drained();

    // Inverted clamps, no idling, and a timeout run long enough to saturate
    // both the timeout and the retry count.
    set_limits('1, '0, '1);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    push_op(OpInit, '0);
    repeat (300) push_op(OpTimeout, random_rtt());
    queue_random_ops(RandomOps);
    wait_drained();
    tx_idle_pct <= 30;
    rx_idle_pct <= 30;

    set_limits(20'd100, 20'd5000, RetryW'($urandom_range(1, 8)));
    queue_random_ops(RandomOps);
    wait_drained();

    set_limits(CfgMsW'($urandom()), CfgMsW'($urandom()), RetryW'($urandom()));
    queue_random_ops(RandomOps);
    wait_drained();

    set_limits('0, '0, 8'd1);
    queue_random_ops(RandomOps);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (estimates_due.size() != 0) begin
      report_mismatch($sformatf("%0d estimates never received a result",
                                estimates_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rre_pkg.sv
hdl/rre_cfg.sv
hdl/rre_core.sv
hdl/rre_alarm.sv
hdl/rtt_rto_estimator.sv
tb/tb_rtt_rto_estimator.sv
